// ===== rtl/gsrs_pkg.sv =====
// Shared constants and types for the grouped slice row selector.
// No dependencies; used by every module of the block.
package gsrs_pkg;

    // Row index and slot widths
    localparam int GROUP_W = 31;
    // Running total width and its saturation width
    localparam int TOTAL_W = 32;
    localparam int ROW_BITS = 32;
    // Configuration data width and register index width
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 3;
    // Signed widths for relative slice ends and their differences
    localparam int SPAN_W = CFG_W + 1;
    localparam int DIFF_W = SPAN_W + 1;
    // Divider sizing: one quotient bit per step
    localparam int DIV_STEPS = GROUP_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Saturation limit of the running total
    localparam logic [TOTAL_W:0] ROWS_LIMIT =
        {{(TOTAL_W + 1 - ROW_BITS){1'b0}}, {ROW_BITS{1'b1}}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_START  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_ABSENT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_STOP   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ABSENT  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_STEP   = CFG_IDX_W'(4);

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_SPAN,
        ST_DIV,
        ST_SUM
    } gsrs_state_t;

endpackage

// ===== rtl/grouped_slice_row_selector.sv =====
// Top level of the grouped slice row selector: sequencer, slice datapath, totals.
// Depends on gsrs_pkg and instantiates gsrs_div.
// One request at a time: the input stalls from accept until the sequencer returns to idle,
//   through the wrap, span, divide and sum states for a nonzero step, skipping the divider
//   for step zero; an empty group frees the input after the span state.
// A finished result waits in the output register while the next request is worked on.
// Reset (rst_n, async, active low) clears state, totals and the slice registers to defaults.
module grouped_slice_row_selector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [gsrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsrs_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [gsrs_pkg::GROUP_W-1:0]    group_end,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [gsrs_pkg::GROUP_W-1:0]    first_row,
    output logic [gsrs_pkg::GROUP_W-1:0]    row_count,
    output logic [gsrs_pkg::GROUP_W-1:0]    group_slot,
    output logic [gsrs_pkg::TOTAL_W-1:0]    rows_total
);
    import gsrs_pkg::*;

    // Sequencer
    gsrs_state_t state_reg, state_next;
    logic        in_take;
    logic        div_load;
    logic        out_load;
    logic        out_free;

    // Slice configuration
    logic [CFG_W-1:0] slice_start_reg;
    logic             start_absent_reg;
    logic [CFG_W-1:0] slice_stop_reg;
    logic             stop_absent_reg;
    logic [CFG_W-1:0] slice_step_reg;

    // Per-group working registers
    logic [GROUP_W-1:0]       prev_end_reg;
    logic [GROUP_W-1:0]       off0_reg;
    logic [GROUP_W-1:0]       n_reg;
    logic signed [SPAN_W-1:0] s_rel_reg;
    logic signed [SPAN_W-1:0] e_rel_reg;
    logic [GROUP_W-1:0]       dvs_reg;
    logic [GROUP_W-1:0]       first_hold_reg;
    logic [GROUP_W-1:0]       cnt_m1_reg;

    // Running state and result registers
    logic [TOTAL_W-1:0] rows_reg;
    logic [GROUP_W-1:0] groups_reg;
    logic               out_valid_reg;
    logic [GROUP_W-1:0] first_row_reg;
    logic [GROUP_W-1:0] row_count_reg;
    logic [GROUP_W-1:0] group_slot_reg;

    // Step classification
    logic step_neg;
    logic step_zero;

    // Group size at accept
    logic [GROUP_W-1:0] n_calc;

    // End normalization (ST_WRAP)
    logic signed [SPAN_W-1:0] sta_x, sto_x, n_x;
    logic signed [SPAN_W-1:0] sta_wrap, sto_wrap, n_m1;
    logic signed [SPAN_W-1:0] s_base, s_sel, e_sel;
    logic [CFG_W-1:0]         step_abs;

    // Span and count setup (ST_SPAN)
    logic signed [DIFF_W-1:0] s_ext, e_ext, dm1;
    logic                     zero_hit;
    logic                     span_empty;
    logic [GROUP_W-1:0]       first_calc;
    logic [GROUP_W-1:0]       zero_cnt_m1;

    // Divider interface
    logic               div_done;
    logic [GROUP_W-1:0] div_quot;

    // Totals (ST_SUM)
    logic [TOTAL_W:0]   sum_raw;
    logic [TOTAL_W-1:0] sum_sat;

    assign step_neg  = slice_step_reg[CFG_W-1];
    assign step_zero = (slice_step_reg == '0);
    assign out_free  = !out_valid_reg || !out_stall;

    // Group size; a group end below the previous end means an empty group
    assign n_calc = (group_end >= prev_end_reg) ? (group_end - prev_end_reg) : '0;

    // Resolve absent, negative and out-of-range slice ends relative to the group
    always_comb
    begin
        sta_x    = {slice_start_reg[CFG_W-1], slice_start_reg};
        sto_x    = {slice_stop_reg[CFG_W-1], slice_stop_reg};
        n_x      = {{(SPAN_W - GROUP_W){1'b0}}, n_reg};
        sta_wrap = sta_x + n_x;
        sto_wrap = sto_x + n_x;
        n_m1     = n_x - SPAN_W'(1);

        // Start: positive step clamps at zero, step zero keeps it for the range check
        s_base = start_absent_reg ? '0 : (sta_x[SPAN_W-1] ? sta_wrap : sta_x);
        if (step_neg)
        begin
            s_sel = (start_absent_reg || (sta_x >= n_x)) ? n_m1
                  : (sta_x[SPAN_W-1] ? sta_wrap : sta_x);
        end
        else
        begin
            s_sel = (!step_zero && s_base[SPAN_W-1]) ? '0 : s_base;
        end

        // Stop: positive step clamps at the group end, negative step at one before the group's first row
        if (step_neg)
        begin
            e_sel = stop_absent_reg ? '1
                  : sto_x[SPAN_W-1] ? (sto_wrap[SPAN_W-1] ? '1 : sto_wrap)
                  : sto_x;
        end
        else
        begin
            e_sel = stop_absent_reg ? n_x
                  : sto_x[SPAN_W-1] ? sto_wrap
                  : ((sto_x > n_x) ? n_x : sto_x);
        end

        step_abs = step_neg ? (~slice_step_reg + CFG_W'(1)) : slice_step_reg;
    end

    // Span minus one feeds the divider: ceil(a / b) = floor((a - 1) / b) + 1
    always_comb
    begin
        s_ext = {s_rel_reg[SPAN_W-1], s_rel_reg};
        e_ext = {e_rel_reg[SPAN_W-1], e_rel_reg};
        dm1   = step_neg ? (s_ext + ~e_ext) : (e_ext + ~s_ext);

        // Step zero selects the start row stop times, if it is inside the group and stop is positive
        zero_hit = !s_rel_reg[SPAN_W-1] && (s_rel_reg < n_x) && !stop_absent_reg
                && !slice_stop_reg[CFG_W-1] && (slice_stop_reg != '0);

        span_empty  = step_zero ? !zero_hit : dm1[DIFF_W-1];
        first_calc  = s_rel_reg[GROUP_W-1:0] + off0_reg;
        zero_cnt_m1 = slice_stop_reg[GROUP_W-1:0] - GROUP_W'(1);
    end

    // Saturating running total; the +1 restores the count from count minus one
    always_comb
    begin
        sum_raw = {1'b0, rows_reg} + {{(TOTAL_W + 1 - GROUP_W){1'b0}}, cnt_m1_reg}
                + (TOTAL_W + 1)'(1);
        sum_sat = (sum_raw > ROWS_LIMIT) ? ROWS_LIMIT[TOTAL_W-1:0] : sum_raw[TOTAL_W-1:0];
    end

    gsrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (dm1[GROUP_W-1:0]),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                priority if (span_empty)
                begin
                    state_next = ST_IDLE;
                end
                else if (step_zero)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        in_take  = (state_reg == ST_IDLE) && in_valid;
        div_load = (state_reg == ST_SPAN) && !span_empty && !step_zero;
        out_load = (state_reg == ST_SUM) && out_free;
    end

    // Control state, configuration and running totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slice_start_reg  <= '0;
            start_absent_reg <= 1'b1;
            slice_stop_reg   <= '0;
            stop_absent_reg  <= 1'b1;
            slice_step_reg   <= CFG_W'(1);
            prev_end_reg     <= '0;
            rows_reg         <= '0;
            groups_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_SLICE_START:  slice_start_reg  <= cfg_data;
                    REG_START_ABSENT: start_absent_reg <= cfg_data[0];
                    REG_SLICE_STOP:   slice_stop_reg   <= cfg_data;
                    REG_STOP_ABSENT:  stop_absent_reg  <= cfg_data[0];
                    REG_SLICE_STEP:   slice_step_reg   <= cfg_data;
                    default:          ;
                endcase
            end

            // advance the group boundary on every request, empty or not
            if (in_take)
            begin
                prev_end_reg <= group_end;
            end

            if (out_load)
            begin
                rows_reg   <= sum_sat;
                groups_reg <= groups_reg + GROUP_W'(1);
            end

            // a load in the same cycle as a pop keeps the register full
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            off0_reg <= prev_end_reg;
            n_reg    <= n_calc;
        end

        if (state_reg == ST_WRAP)
        begin
            s_rel_reg <= s_sel;
            e_rel_reg <= e_sel;
            dvs_reg   <= step_abs[GROUP_W-1:0];
        end

        if (state_reg == ST_SPAN)
        begin
            first_hold_reg <= first_calc;
            cnt_m1_reg     <= zero_cnt_m1;
        end

        if ((state_reg == ST_DIV) && div_done)
        begin
            cnt_m1_reg <= div_quot;
        end

        if (out_load)
        begin
            first_row_reg  <= first_hold_reg;
            row_count_reg  <= cnt_m1_reg + GROUP_W'(1);
            group_slot_reg <= groups_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign first_row  = first_row_reg;
    assign row_count  = row_count_reg;
    assign group_slot = group_slot_reg;
    // the running total only moves on the next load, so it serves as the result field
    assign rows_total = rows_reg;

endmodule

// ===== rtl/gsrs_div.sv =====
// Radix-2 restoring divider, one quotient bit shifted in per cycle.
// Depends on gsrs_pkg for widths and step count.
module gsrs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [gsrs_pkg::GROUP_W-1:0]  dividend,
    input  logic [gsrs_pkg::GROUP_W-1:0]  divisor,
    output logic                          done,
    output logic [gsrs_pkg::GROUP_W-1:0]  quotient
);
    import gsrs_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [GROUP_W-1:0]   dq_reg, dq_next;
    logic [GROUP_W-1:0]   rem_reg, rem_next;
    logic [GROUP_W-1:0]   dvs_reg, dvs_next;
    logic [GROUP_W:0]     rem_sh;
    logic [GROUP_W+1:0]   trial;
    logic                 take;

    always_comb
    begin
        // shift the next dividend bit into the partial remainder
        rem_sh = {rem_reg, dq_reg[GROUP_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, dvs_reg};
        take   = !trial[GROUP_W+1];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[GROUP_W-2:0], take};
            rem_next = take ? trial[GROUP_W-1:0] : rem_sh[GROUP_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ===== rtl/gsrs_checker.sv =====
// Port-level checker for the grouped slice row selector, bound to the top level.
// Depends on gsrs_pkg for port widths.
module gsrs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [gsrs_pkg::GROUP_W-1:0]  row_count,
    input logic [gsrs_pkg::TOTAL_W-1:0]  rows_total
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // One request at a time: the input closes right after an accept
    a_in_close: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open the cycle after an accept");

    // No result can appear the cycle right after an accept
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result too early after accept");

    // Every delivered group selects at least one row
    a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row_count != '0)
        else $error("zero row count delivered");

    // The running total never goes down
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> rows_total >= $past(rows_total))
        else $error("running total decreased");

endmodule

bind grouped_slice_row_selector gsrs_checker u_checker (.*);
